### design/dtfd_pkg.sv
`timescale 1ns / 1ps

package dtfd_pkg;

   localparam int PIX_W      = 32;
   localparam int DIM_W      = 13;
   localparam int POS_W      = 12;
   localparam int TILE_SHIFT = 4;
   localparam int TIDX_W     = POS_W - TILE_SHIFT;
   localparam int BOX_W      = TIDX_W + 1;
   localparam int CNT_W      = 17;
   localparam int SCORE_W    = 7;
   localparam int NUM_W      = CNT_W + SCORE_W;
   localparam int AREA_W     = 2 * TIDX_W + 1;
   localparam int DIVCNT_W   = $clog2(NUM_W);
   localparam int LIM_W      = 11;
   localparam int CSR_IDX_W  = 1;

   localparam int DEF_MAX_TILE_COLS = 256;
   localparam int DEF_MAX_TILE_ROWS = 256;

   localparam logic [DIM_W-1:0]     DIM_MAX          = 13'd4096;
   localparam logic [DIM_W-1:0]     DIM_MIN          = 13'd1;
   localparam logic [DIM_W-1:0]     WIDTH_RESET      = 13'd1920;
   localparam logic [DIM_W-1:0]     HEIGHT_RESET     = 13'd1080;
   localparam logic [SCORE_W-1:0]   SCORE_SCALE      = 7'd100;
   localparam logic [BOX_W-1:0]     BOX_EMPTY        = '1;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic eval;
      logic prep;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic frame_end;
      logic snap_dirty;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

### design/dtfd_req_if.sv
`timescale 1ns / 1ps

interface dtfd_req_if;
   logic                        valid;
   logic                        ready;
   logic [dtfd_pkg::PIX_W-1:0]  old_pixel;
   logic [dtfd_pkg::PIX_W-1:0]  new_pixel;
   logic                        frame_start;

   modport source (output valid, output old_pixel, output new_pixel, output frame_start,
                   input ready);
   modport sink   (input valid, input old_pixel, input new_pixel, input frame_start,
                   output ready);
endinterface

### design/dtfd_rsp_if.sv
`timescale 1ns / 1ps

interface dtfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          any_dirty;
   logic [dtfd_pkg::TIDX_W-1:0]   tile_left;
   logic [dtfd_pkg::TIDX_W-1:0]   tile_top;
   logic [dtfd_pkg::TIDX_W-1:0]   tile_right;
   logic [dtfd_pkg::TIDX_W-1:0]   tile_bottom;
   logic [dtfd_pkg::CNT_W-1:0]    dirty_count;
   logic [dtfd_pkg::SCORE_W-1:0]  score;
   logic [dtfd_pkg::POS_W-1:0]    bound_x;
   logic [dtfd_pkg::POS_W-1:0]    bound_y;
   logic [dtfd_pkg::DIM_W-1:0]    bound_w;
   logic [dtfd_pkg::DIM_W-1:0]    bound_h;

   modport source (output valid, output any_dirty, output tile_left, output tile_top,
                   output tile_right, output tile_bottom, output dirty_count, output score,
                   output bound_x, output bound_y, output bound_w, output bound_h,
                   input ready);
   modport sink   (input valid, input any_dirty, input tile_left, input tile_top,
                   input tile_right, input tile_bottom, input dirty_count, input score,
                   input bound_x, input bound_y, input bound_w, input bound_h,
                   output ready);
endinterface

### design/dirty_tile_frame_diff_top.sv
`timescale 1ns / 1ps
// channel   dir   beat
// req_chan  in    old_pixel, new_pixel, frame_start (one pixel pair)
// rsp_chan  out   frame summary: any_dirty, tile box, dirty_count, score, pixel bounds
// csr_*     in    csr_write_en, csr_index, csr_wdata (frame_width, frame_height)
//
// a pixel is accepted with its band flag read, then the flag read-modify-write follows
// the last pixel of a frame adds area/bounds setup, the divider for the score (only when a
// tile is dirty) and the load of the result register, which waits until that register is free
// after reset the band flag memory is swept, with req ready low
// a waiting summary does not block pixels; only the next summary waits for it
module dirty_tile_frame_diff_top #(
   parameter int MAX_TILE_COLS = dtfd_pkg::DEF_MAX_TILE_COLS,
   parameter int MAX_TILE_ROWS = dtfd_pkg::DEF_MAX_TILE_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   dtfd_req_if.sink                        req_chan,
   dtfd_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [dtfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dtfd_pkg::DIM_W-1:0]      csr_wdata
);

   dtfd_pkg::cmd_type    cmd;
   dtfd_pkg::status_type status;

   dtfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dtfd_datapath #(
      .MAX_TILE_COLS (MAX_TILE_COLS),
      .MAX_TILE_ROWS (MAX_TILE_ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_old_pixel   (req_chan.old_pixel),
      .req_new_pixel   (req_chan.new_pixel),
      .req_frame_start (req_chan.frame_start),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_any_dirty   (rsp_chan.any_dirty),
      .rsp_tile_left   (rsp_chan.tile_left),
      .rsp_tile_top    (rsp_chan.tile_top),
      .rsp_tile_right  (rsp_chan.tile_right),
      .rsp_tile_bottom (rsp_chan.tile_bottom),
      .rsp_dirty_count (rsp_chan.dirty_count),
      .rsp_score       (rsp_chan.score),
      .rsp_bound_x     (rsp_chan.bound_x),
      .rsp_bound_y     (rsp_chan.bound_y),
      .rsp_bound_w     (rsp_chan.bound_w),
      .rsp_bound_h     (rsp_chan.bound_h)
   );

endmodule

### design/dtfd_ctrl.sv
`timescale 1ns / 1ps

module dtfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dtfd_pkg::status_type   status,
   output dtfd_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_PREP  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_LOAD  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.frame_end ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.snap_dirty ? ST_DIV : ST_LOAD;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_out = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/dtfd_datapath.sv
`timescale 1ns / 1ps

module dtfd_datapath #(
   parameter int MAX_TILE_COLS = dtfd_pkg::DEF_MAX_TILE_COLS,
   parameter int MAX_TILE_ROWS = dtfd_pkg::DEF_MAX_TILE_ROWS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dtfd_pkg::cmd_type                  cmd,
   output dtfd_pkg::status_type               status,
   input  logic [dtfd_pkg::PIX_W-1:0]         req_old_pixel,
   input  logic [dtfd_pkg::PIX_W-1:0]         req_new_pixel,
   input  logic                               req_frame_start,
   input  logic                               csr_write_en,
   input  logic [dtfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dtfd_pkg::DIM_W-1:0]         csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_any_dirty,
   output logic [dtfd_pkg::TIDX_W-1:0]        rsp_tile_left,
   output logic [dtfd_pkg::TIDX_W-1:0]        rsp_tile_top,
   output logic [dtfd_pkg::TIDX_W-1:0]        rsp_tile_right,
   output logic [dtfd_pkg::TIDX_W-1:0]        rsp_tile_bottom,
   output logic [dtfd_pkg::CNT_W-1:0]         rsp_dirty_count,
   output logic [dtfd_pkg::SCORE_W-1:0]       rsp_score,
   output logic [dtfd_pkg::POS_W-1:0]         rsp_bound_x,
   output logic [dtfd_pkg::POS_W-1:0]         rsp_bound_y,
   output logic [dtfd_pkg::DIM_W-1:0]         rsp_bound_w,
   output logic [dtfd_pkg::DIM_W-1:0]         rsp_bound_h
);

   localparam int DIM_W   = dtfd_pkg::DIM_W;
   localparam int POS_W   = dtfd_pkg::POS_W;
   localparam int TS      = dtfd_pkg::TILE_SHIFT;
   localparam int TIDX_W  = dtfd_pkg::TIDX_W;
   localparam int BOX_W   = dtfd_pkg::BOX_W;
   localparam int CNT_W   = dtfd_pkg::CNT_W;
   localparam int NUM_W   = dtfd_pkg::NUM_W;
   localparam int AREA_W  = dtfd_pkg::AREA_W;
   localparam int SCORE_W = dtfd_pkg::SCORE_W;
   localparam int LIM_W   = dtfd_pkg::LIM_W;
   localparam int DC_W    = dtfd_pkg::DIVCNT_W;
   localparam int BAND_AW = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;

   localparam logic [BAND_AW-1:0] BAND_LAST = BAND_AW'(MAX_TILE_COLS - 1);
   localparam logic [LIM_W-1:0]   COL_LIMIT = LIM_W'(MAX_TILE_COLS - 1);
   localparam logic [LIM_W-1:0]   ROW_LIMIT = LIM_W'(MAX_TILE_ROWS - 1);
   localparam logic [DC_W-1:0]    DIV_LAST  = DC_W'(NUM_W - 1);

   // configuration
   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [DIM_W-1:0] w_eff, h_eff;

   // scan position and per-frame tallies
   logic [POS_W-1:0]  col_ff, row_ff, col_in, row_in, col_eff, row_eff;
   logic [CNT_W-1:0]  tally_ff, tally_in, upd_tally;
   logic [BOX_W-1:0]  left_ff, left_in, upd_left, top_ff, top_in, upd_top;
   logic [TIDX_W-1:0] right_ff, right_in, upd_right, bottom_ff, bottom_in, upd_bottom;

   // pixel beat held for the band update
   logic [TIDX_W-1:0] tc_raw, tr_raw, tc_sel, tr_sel, tc_ff, tr_ff;
   logic              first_ff, diff_ff, hit, line_end, frame_end;

   // band flags
   logic               band_mem [MAX_TILE_COLS];
   logic               band_rd_ff;
   logic [BAND_AW-1:0] clr_idx_ff;

   // frame summary
   logic [CNT_W-1:0]  snap_tally_ff;
   logic [BOX_W-1:0]  snap_left_ff, snap_top_ff;
   logic [TIDX_W-1:0] snap_right_ff, snap_bottom_ff;
   logic [TIDX_W:0]   span_x, span_y;
   logic [AREA_W:0]   area_full;
   logic [NUM_W-1:0]  num_full;
   logic [DIM_W-1:0]  bx_full, by_full, ex_full, ey_full, ex_clip, ey_clip;
   logic [DIM_W-1:0]  bound_w_in, bound_h_in, bound_w_ff, bound_h_ff;

   // divider
   logic [AREA_W-1:0] area_ff, rem_ff, rem_in;
   logic [AREA_W:0]   rem_sh;
   logic [NUM_W-1:0]  quo_ff;
   logic [DC_W-1:0]   div_cnt_ff;
   logic              rem_ge;
   logic [SCORE_W-1:0] score_sat;

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= dtfd_pkg::WIDTH_RESET;
         frame_height_ff <= dtfd_pkg::HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            dtfd_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            dtfd_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = dtfd_pkg::DIM_MIN;
      end else if (frame_width_ff > dtfd_pkg::DIM_MAX) begin
         w_eff = dtfd_pkg::DIM_MAX;
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = dtfd_pkg::DIM_MIN;
      end else if (frame_height_ff > dtfd_pkg::DIM_MAX) begin
         h_eff = dtfd_pkg::DIM_MAX;
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // tile of the incoming beat
   always_comb begin
      col_eff = req_frame_start ? '0 : col_ff;
      row_eff = req_frame_start ? '0 : row_ff;
      tc_raw  = col_eff[POS_W-1:TS];
      tr_raw  = row_eff[POS_W-1:TS];
      tc_sel  = (LIM_W'(tc_raw) > COL_LIMIT) ? COL_LIMIT[TIDX_W-1:0] : tc_raw;
      tr_sel  = (LIM_W'(tr_raw) > ROW_LIMIT) ? ROW_LIMIT[TIDX_W-1:0] : tr_raw;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tc_ff      <= tc_sel;
         tr_ff      <= tr_sel;
         first_ff   <= (col_eff[TS-1:0] == '0) && (row_eff[TS-1:0] == '0);
         diff_ff    <= req_old_pixel != req_new_pixel;
         band_rd_ff <= band_mem[BAND_AW'(tc_sel)];
      end
      if (cmd.clear_step) begin
         band_mem[clr_idx_ff] <= 1'b0;
      end else if (cmd.eval && (first_ff || hit)) begin
         band_mem[BAND_AW'(tc_ff)] <= hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_step && clr_idx_ff != BAND_LAST) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   assign hit       = diff_ff && (first_ff || !band_rd_ff);
   assign line_end  = (DIM_W'(col_ff) + 1'b1) >= w_eff;
   assign frame_end = line_end && ((DIM_W'(row_ff) + 1'b1) >= h_eff);

   always_comb begin
      upd_tally  = tally_ff + CNT_W'(hit);
      upd_left   = (hit && BOX_W'(tc_ff) < left_ff) ? BOX_W'(tc_ff) : left_ff;
      upd_top    = (hit && BOX_W'(tr_ff) < top_ff) ? BOX_W'(tr_ff) : top_ff;
      upd_right  = (hit && tc_ff > right_ff) ? tc_ff : right_ff;
      upd_bottom = (hit && tr_ff > bottom_ff) ? tr_ff : bottom_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      tally_in   = tally_ff;
      left_in    = left_ff;
      top_in     = top_ff;
      right_in   = right_ff;
      bottom_in  = bottom_ff;
      if ((cmd.accept && req_frame_start) || (cmd.eval && frame_end)) begin
         col_in    = '0;
         row_in    = '0;
         tally_in  = '0;
         left_in   = dtfd_pkg::BOX_EMPTY;
         top_in    = dtfd_pkg::BOX_EMPTY;
         right_in  = '0;
         bottom_in = '0;
      end else if (cmd.eval) begin
         tally_in  = upd_tally;
         left_in   = upd_left;
         top_in    = upd_top;
         right_in  = upd_right;
         bottom_in = upd_bottom;
         if (line_end) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         tally_ff  <= '0;
         left_ff   <= dtfd_pkg::BOX_EMPTY;
         top_ff    <= dtfd_pkg::BOX_EMPTY;
         right_ff  <= '0;
         bottom_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         tally_ff  <= tally_in;
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval && frame_end) begin
         snap_tally_ff  <= upd_tally;
         snap_left_ff   <= upd_left;
         snap_top_ff    <= upd_top;
         snap_right_ff  <= upd_right;
         snap_bottom_ff <= upd_bottom;
      end
   end

   // box area, scaled count and clipped pixel bounds
   always_comb begin
      span_x     = {1'b0, snap_right_ff} - {1'b0, snap_left_ff[TIDX_W-1:0]} + 1'b1;
      span_y     = {1'b0, snap_bottom_ff} - {1'b0, snap_top_ff[TIDX_W-1:0]} + 1'b1;
      area_full  = span_x * span_y;
      num_full   = snap_tally_ff * dtfd_pkg::SCORE_SCALE;
      bx_full    = {1'b0, snap_left_ff[TIDX_W-1:0], {TS{1'b0}}};
      by_full    = {1'b0, snap_top_ff[TIDX_W-1:0], {TS{1'b0}}};
      ex_full    = {({1'b0, snap_right_ff} + 1'b1), {TS{1'b0}}};
      ey_full    = {({1'b0, snap_bottom_ff} + 1'b1), {TS{1'b0}}};
      ex_clip    = (ex_full > w_eff) ? w_eff : ex_full;
      ey_clip    = (ey_full > h_eff) ? h_eff : ey_full;
      bound_w_in = (ex_clip > bx_full) ? ex_clip - bx_full : '0;
      bound_h_in = (ey_clip > by_full) ? ey_clip - by_full : '0;
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      rem_ge = rem_sh >= {1'b0, area_ff};
      rem_in = rem_ge ? AREA_W'(rem_sh - {1'b0, area_ff}) : rem_sh[AREA_W-1:0];
      score_sat = (quo_ff > NUM_W'(dtfd_pkg::SCORE_SCALE)) ?
                  dtfd_pkg::SCORE_SCALE : quo_ff[SCORE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         area_ff    <= area_full[AREA_W-1:0];
         quo_ff     <= num_full;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
         bound_w_ff <= bound_w_in;
         bound_h_ff <= bound_h_in;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_in;
         quo_ff     <= {quo_ff[NUM_W-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (snap_tally_ff != '0) begin
            rsp_any_dirty   <= 1'b1;
            rsp_tile_left   <= snap_left_ff[TIDX_W-1:0];
            rsp_tile_top    <= snap_top_ff[TIDX_W-1:0];
            rsp_tile_right  <= snap_right_ff;
            rsp_tile_bottom <= snap_bottom_ff;
            rsp_dirty_count <= snap_tally_ff;
            rsp_score       <= score_sat;
            rsp_bound_x     <= bx_full[POS_W-1:0];
            rsp_bound_y     <= by_full[POS_W-1:0];
            rsp_bound_w     <= bound_w_ff;
            rsp_bound_h     <= bound_h_ff;
         end else begin
            rsp_any_dirty   <= 1'b0;
            rsp_tile_left   <= '0;
            rsp_tile_top    <= '0;
            rsp_tile_right  <= '0;
            rsp_tile_bottom <= '0;
            rsp_dirty_count <= '0;
            rsp_score       <= '0;
            rsp_bound_x     <= '0;
            rsp_bound_y     <= '0;
            rsp_bound_w     <= '0;
            rsp_bound_h     <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign status.clear_done = clr_idx_ff == BAND_LAST;
   assign status.frame_end  = frame_end;
   assign status.snap_dirty = snap_tally_ff != '0;
   assign status.div_done   = div_cnt_ff == DIV_LAST;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_frame_end_wraps: assert property (@(posedge clock) disable iff (reset)
      cmd.eval && frame_end |=> col_ff == '0 && row_ff == '0 && tally_ff == '0)
      else $error("tallies not cleared after frame end");

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      cmd.prep && snap_tally_ff != '0 |->
         snap_left_ff[TIDX_W-1:0] <= snap_right_ff &&
         snap_top_ff[TIDX_W-1:0] <= snap_bottom_ff)
      else $error("dirty box inverted");

   a_clean_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_any_dirty |-> rsp_dirty_count == '0 && rsp_score == '0)
      else $error("clean frame summary carries a count");

endmodule
